/* src/hsl2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared constants, types and helpers for the 240-scale HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  localparam int unsigned ScaleIn   = 240;
  localparam int unsigned HalfIn    = 120;
  localparam int unsigned ThirdTurn = 80;
  localparam int unsigned SixthTurn = 40;

  localparam int unsigned CompW  = 8;   // one colour component
  localparam int unsigned WordW  = 24;  // three components, packed
  localparam int unsigned KW     = 6;   // sector weight 0..40
  localparam int unsigned VW     = 16;  // v1, v2 and v2-v1, unit 57600
  localparam int unsigned NumW   = 22;  // 40*v1 + (v2-v1)*k
  localparam int unsigned XW     = 27;  // 17*num
  localparam int unsigned YW     = 15;  // 17*num / 2048
  localparam int unsigned ProdW  = 30;  // y * reciprocal of 75
  localparam int unsigned RecipShift = 21;

  // 255/(40*57600) = 17/153600 = 17/(2048*75); 1/75 ~ 27963 / 2^21
  localparam logic [4:0]    OutNum   = 5'd17;
  localparam int unsigned   DivShift = 11;
  localparam logic [YW-1:0] Recip75  = 15'd27963;

  typedef struct packed {
    logic en_num;
    logic en_scl;
    logic en_out;
  } chan_ctrl_t;

  // Weight 0..40 for a hue position 0..239
  function automatic logic [KW-1:0] sector_weight(input logic [CompW-1:0] t);
    logic [CompW-1:0] w;
    begin
      if (t < CompW'(SixthTurn)) begin
        w = t;
      end else if (t < CompW'(3 * SixthTurn)) begin
        w = CompW'(SixthTurn);
      end else if (t < CompW'(4 * SixthTurn)) begin
        w = CompW'(4 * SixthTurn) - t;
      end else begin
        w = '0;
      end
      return w[KW-1:0];
    end
  endfunction

endpackage

/* src/hsl2rgb_chan.sv */
// ----------------------------------------------------------------------------
// hsl2rgb_chan
// One colour channel: sector blend of v1/v2 and exact scaling to 0..255,
// three register stages.
// ----------------------------------------------------------------------------
module hsl2rgb_chan
  import hsl2rgb_pkg::*;
(
  input  logic             clk_i,
  input  chan_ctrl_t       ctrl_i,
  input  logic [VW-1:0]    v1_i,
  input  logic [VW-1:0]    diff_i,
  input  logic [KW-1:0]    k_i,
  output logic [CompW-1:0] chan_o
);

  logic [NumW-1:0]  num_d, num_q;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y_d, y_q;
  logic [ProdW-1:0] prod;
  logic [8:0]       quo;
  logic [CompW-1:0] chan_d, chan_q;

  assign num_d = NumW'(v1_i) * NumW'(SixthTurn) + NumW'(diff_i) * NumW'(k_i);

  assign x   = XW'(num_q) * XW'(OutNum);
  assign y_d = YW'(x >> DivShift);

  // floor(y/75) is exact through this reciprocal for y below 28728
  assign prod   = ProdW'(y_q) * ProdW'(Recip75);
  assign quo    = prod[ProdW-1:RecipShift];
  assign chan_d = quo[8] ? '1 : quo[CompW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_num) begin
      num_q <= num_d;
    end
    if (ctrl_i.en_scl) begin
      y_q <= y_d;
    end
    if (ctrl_i.en_out) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

/* src/hsl_to_rgb_240_scale_top.sv */
// ----------------------------------------------------------------------------
// hsl_to_rgb_240_scale_top
// HSL (0..240 scale) to RGB (0..255) converter, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one colour per word: hue, saturation, lightness.
//   Hue 240..255 wraps by 240; saturation and lightness clamp at 240.
//   Master stream gives red, green, blue, each the floor of the exact value.
//   Throughput: one word per cycle while m_axis_tready is high; the five
//   register stages each hold a valid bit and load whenever they are empty
//   or the stage after can load, so bubbles close up while the receiver stalls.
//   While m_axis_tready is low the result holds on the master side; words
//   are still accepted until every stage is full, then s_axis_tready drops.
//   Nothing is lost or repeated across a stall.
//   Reset clears all valid bits; no result is presented after reset until
//   a word has been accepted.
//   Stage 1: clamp, hue positions and l*s. Stage 2: v1 and v2-v1.
//   Stages 3-5 per channel: blend, scale by 17/2048, divide by 75.
// ----------------------------------------------------------------------------
module hsl_to_rgb_240_scale_top
  import hsl2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [WordW-1:0] s_axis_tdata,   // hue, saturation, lightness
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [WordW-1:0] m_axis_tdata    // red, green, blue
);

  logic [4:0] vld_q, vld_d, rdy;

  // ready chain: a stage loads when it is empty or its successor moves
  always_comb begin
    rdy[4] = !vld_q[4] || m_axis_tready;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int i = 1; i < 5; i++) begin
      if (rdy[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[4];

  // ---------------- stage 1 ----------------
  logic [CompW-1:0] hue_in, sat_in, lit_in;
  logic [CompW-1:0] h, s_c, l_c, tr, tb;
  logic [8:0]       h80;
  logic [VW-1:0]    ls_d;
  logic [CompW-1:0] s_q1, l_q1;
  logic [VW-1:0]    ls_q1;
  logic [KW-1:0]    kr_q1, kg_q1, kb_q1;

  assign hue_in = s_axis_tdata[7:0];
  assign sat_in = s_axis_tdata[15:8];
  assign lit_in = s_axis_tdata[23:16];

  assign h   = (hue_in >= CompW'(ScaleIn)) ? hue_in - CompW'(ScaleIn) : hue_in;
  assign s_c = (sat_in > CompW'(ScaleIn)) ? CompW'(ScaleIn) : sat_in;
  assign l_c = (lit_in > CompW'(ScaleIn)) ? CompW'(ScaleIn) : lit_in;
  assign h80 = {1'b0, h} + 9'(ThirdTurn);
  assign tr  = (h80 >= 9'(ScaleIn)) ? CompW'(h80 - 9'(ScaleIn)) : h80[CompW-1:0];
  assign tb  = (h >= CompW'(ThirdTurn)) ? h - CompW'(ThirdTurn)
                                        : h + CompW'(ScaleIn - ThirdTurn);
  assign ls_d = VW'(l_c) * VW'(s_c);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s_q1  <= s_c;
      l_q1  <= l_c;
      ls_q1 <= ls_d;
      kr_q1 <= sector_weight(tr);
      kg_q1 <= sector_weight(h);
      kb_q1 <= sector_weight(tb);
    end
  end

  // ---------------- stage 2 ----------------
  // zero saturation gives v1 = v2 = 240*l, which is the plain grey
  logic [17:0]   v2w, l480;
  logic [VW-1:0] v2, v1_d, diff_d;
  logic [VW-1:0] v1_q2, diff_q2;
  logic [KW-1:0] kr_q2, kg_q2, kb_q2;

  always_comb begin
    if (l_q1 < CompW'(HalfIn)) begin
      v2w = 18'(l_q1) * 18'(ScaleIn) + 18'(ls_q1);
    end else begin
      v2w = (18'(l_q1) + 18'(s_q1)) * 18'(ScaleIn) - 18'(ls_q1);
    end
  end

  assign l480   = 18'(l_q1) * 18'(2 * ScaleIn);
  assign v2     = v2w[VW-1:0];
  assign v1_d   = VW'(l480 - v2w);
  assign diff_d = v2 - v1_d;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      v1_q2   <= v1_d;
      diff_q2 <= diff_d;
      kr_q2   <= kr_q1;
      kg_q2   <= kg_q1;
      kb_q2   <= kb_q1;
    end
  end

  // ---------------- stages 3..5 ----------------
  chan_ctrl_t       cctrl;
  logic [CompW-1:0] red, green, blue;

  assign cctrl.en_num = rdy[2];
  assign cctrl.en_scl = rdy[3];
  assign cctrl.en_out = rdy[4];

  hsl2rgb_chan u_red (
    .clk_i  (clk_i),
    .ctrl_i (cctrl),
    .v1_i   (v1_q2),
    .diff_i (diff_q2),
    .k_i    (kr_q2),
    .chan_o (red)
  );

  hsl2rgb_chan u_green (
    .clk_i  (clk_i),
    .ctrl_i (cctrl),
    .v1_i   (v1_q2),
    .diff_i (diff_q2),
    .k_i    (kg_q2),
    .chan_o (green)
  );

  hsl2rgb_chan u_blue (
    .clk_i  (clk_i),
    .ctrl_i (cctrl),
    .v1_i   (v1_q2),
    .diff_i (diff_q2),
    .k_i    (kb_q2),
    .chan_o (blue)
  );

  assign m_axis_tdata = {blue, green, red};

endmodule

/* tb/hsl_rgb_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_rgb_check
// Watches both streams of the HSL to RGB converter. Each accepted colour is
// converted here with exact integer arithmetic and queued. Each word leaving
// the block is compared field by field against the oldest queued colour.
// ----------------------------------------------------------------------------
module hsl_rgb_check
  import hsl2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             s_ready_i,
  input  logic [WordW-1:0] s_data_i,   // hue, saturation, lightness
  input  logic             m_valid_i,
  input  logic             m_ready_i,
  input  logic [WordW-1:0] m_data_i,   // red, green, blue
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  localparam int unsigned OutScale = 255;
  localparam int unsigned ShowMax  = 10;

  typedef struct packed {
    logic [CompW-1:0] lightness;
    logic [CompW-1:0] saturation;
    logic [CompW-1:0] hue;
  } hsl_t;

  typedef struct packed {
    logic [CompW-1:0] blue;
    logic [CompW-1:0] green;
    logic [CompW-1:0] red;
  } rgb_t;

  typedef struct {
    hsl_t colour;
    rgb_t rgb;
  } due_t;

  due_t rgb_due[$];

  // 0..40 ramp over the hue circle: rising, flat top, falling, zero
  function automatic longint unsigned hue_ramp(input int unsigned pos);
    if (pos < SixthTurn) return pos;
    if (pos < 3 * SixthTurn) return SixthTurn;
    if (pos < 4 * SixthTurn) return 4 * SixthTurn - pos;
    return 0;
  endfunction

  function automatic logic [CompW-1:0] blend_channel(input int unsigned lo,
                                                     input int unsigned hi,
                                                     input int unsigned pos);
    longint unsigned num;
    longint unsigned q;
    num = longint'(SixthTurn) * lo + longint'(hi - lo) * hue_ramp(pos);
    q   = (longint'(OutScale) * num) / (longint'(SixthTurn) * ScaleIn * ScaleIn);
    if (q > OutScale) q = OutScale;
    return q[CompW-1:0];
  endfunction

  function automatic rgb_t convert_hsl(input hsl_t c);
    int unsigned h, s, l, lo, hi;
    rgb_t rgb;
    h = c.hue;
    s = (c.saturation > ScaleIn) ? ScaleIn : c.saturation;
    l = (c.lightness > ScaleIn) ? ScaleIn : c.lightness;
    if (h >= ScaleIn) h = h - ScaleIn;
    if (s == 0) begin
      rgb.red   = CompW'((l * OutScale) / ScaleIn);
      rgb.green = rgb.red;
      rgb.blue  = rgb.red;
      return rgb;
    end
    if (l < HalfIn) hi = l * (ScaleIn + s);
    else hi = (l + s) * ScaleIn - l * s;
    lo = 2 * l * ScaleIn - hi;
    rgb.red   = blend_channel(lo, hi, (h + ThirdTurn) % ScaleIn);
    rgb.green = blend_channel(lo, hi, h);
    rgb.blue  = blend_channel(lo, hi, (h + ScaleIn - ThirdTurn) % ScaleIn);
    return rgb;
  endfunction

  always @(posedge clk_i) begin : watch
    due_t want;
    rgb_t got;
    int   bad;
    int   seen;
    bad  = 0;
    seen = 0;
    if (rst_ni) begin
      if (s_valid_i && s_ready_i) begin
        want.colour = s_data_i;
        want.rgb    = convert_hsl(s_data_i);
        rgb_due.push_back(want);
      end
      if (m_valid_i && m_ready_i) begin
        got  = m_data_i;
        seen = 1;
        if (rgb_due.size() == 0) begin
          bad = 1;
          if (fail_count_o < ShowMax)
            $display("%0t: unexpected word rgb %0d/%0d/%0d", $realtime,
                     got.red, got.green, got.blue);
        end else begin
          want = rgb_due.pop_front();
          if (got.red != want.rgb.red || got.green != want.rgb.green ||
              got.blue != want.rgb.blue) begin
            bad = 1;
            if (fail_count_o < ShowMax)
              $display("%0t: hsl %0d/%0d/%0d expected rgb %0d/%0d/%0d, got %0d/%0d/%0d",
                       $realtime, want.colour.hue, want.colour.saturation,
                       want.colour.lightness, want.rgb.red, want.rgb.green,
                       want.rgb.blue, got.red, got.green, got.blue);
          end
        end
      end
    end
    fail_count_o <= fail_count_o + bad;
    checked_o    <= checked_o + seen;
    pending_o    <= rgb_due.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the HSL to RGB converter: directed corner colours, then
// random colours with random gaps on the input side and random stalls on
// the output side. The checker alongside decides every word.
// ----------------------------------------------------------------------------
module tb;
  import hsl2rgb_pkg::*;

  localparam int unsigned RandomWords = 1300;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxGap      = 11;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [WordW-1:0] s_axis_tdata  = '0;   // hue, saturation, lightness
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [WordW-1:0] m_axis_tdata;         // red, green, blue

  bit          no_gaps;
  int unsigned words_sent;
  int unsigned idle_cycles;
  int          fail_count;
  int          pending;
  int          checked;

  hsl_to_rgb_240_scale_top DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  hsl_rgb_check u_check (
    .clk_i,
    .rst_ni,
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Nothing accepted on either side for too long: the block has hung
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("no word moved for %0d cycles", idle_cycles);
      $display("FAIL hsl_to_rgb_240_scale_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: a fresh stall before every word
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(MaxGap, 0);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Returns at the edge where the word is taken
  task automatic send_hsl(input logic [CompW-1:0] h, input logic [CompW-1:0] s,
                          input logic [CompW-1:0] l);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(MaxGap, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {l, s, h};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  initial begin
    logic [CompW-1:0] h, s, l;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // primaries and secondaries, sector edges, wrapped hue
    send_hsl(8'd0,   8'd240, 8'd120);
    send_hsl(8'd40,  8'd240, 8'd120);
    send_hsl(8'd80,  8'd240, 8'd120);
    send_hsl(8'd120, 8'd240, 8'd120);
    send_hsl(8'd160, 8'd240, 8'd120);
    send_hsl(8'd200, 8'd240, 8'd120);
    send_hsl(8'd239, 8'd240, 8'd120);
    send_hsl(8'd240, 8'd240, 8'd120);
    send_hsl(8'd255, 8'd240, 8'd120);
    send_hsl(8'd39,  8'd200, 8'd60);
    send_hsl(8'd119, 8'd200, 8'd180);
    send_hsl(8'd159, 8'd100, 8'd119);
    // greys, including clamped lightness
    send_hsl(8'd0,   8'd0,   8'd0);
    send_hsl(8'd17,  8'd0,   8'd240);
    send_hsl(8'd255, 8'd0,   8'd255);
    // clamped saturation, black and white ends, lightness either side of half
    send_hsl(8'd100, 8'd255, 8'd100);
    send_hsl(8'd60,  8'd1,   8'd1);
    send_hsl(8'd60,  8'd240, 8'd240);
    send_hsl(8'd60,  8'd240, 8'd0);
    send_hsl(8'd60,  8'd255, 8'd255);
    send_hsl(8'd30,  8'd128, 8'd128);
    send_hsl(8'd200, 8'd170, 8'd85);

    for (int i = 0; i < RandomWords; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(3, 0) == 0);
      h = CompW'($urandom_range(ScaleIn, 0));
      s = CompW'($urandom_range(ScaleIn, 0));
      l = CompW'($urandom_range(ScaleIn, 0));
      case ($urandom_range(9, 0))
        0: begin
          h = CompW'($urandom_range(255, 0));
          s = CompW'($urandom_range(255, 0));
          l = CompW'($urandom_range(255, 0));
        end
        1: s = '0;
        2: h = CompW'(SixthTurn * $urandom_range(6, 0) + $urandom_range(2, 0) - 1);
        3: l = CompW'(HalfIn + $urandom_range(2, 0) - 1);
        default: ;
      endcase
      send_hsl(h, s, l);
    end
    s_axis_tvalid <= 1'b0;
    no_gaps = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d colours sent: corner cases, greys, wrapped hue, clamped inputs, random",
             words_sent);
    $display("%0d results compared under random gaps and stalls, %0d failures",
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS hsl_to_rgb_240_scale_top");
    end else begin
      $display("FAIL hsl_to_rgb_240_scale_top");
    end
    $finish;
  end

endmodule

/* sim.f */
src/hsl2rgb_pkg.sv
src/hsl2rgb_chan.sv
src/hsl_to_rgb_240_scale_top.sv
tb/hsl_rgb_check.sv
tb/tb.sv
